FILE: rtl/signed_integer_alu_64_assert.svh
// assertion macros for the signed 64-bit alu
// used by signed_integer_alu_64, expects clk and rst_n in scope
`ifndef SIGNED_INTEGER_ALU_64_ASSERT_SVH
`define SIGNED_INTEGER_ALU_64_ASSERT_SVH
`ifndef SYNTHESIS
`define SIA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SIA_ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SIA_ASSERT(lbl, prop, msg)
`define SIA_ASSERT_ANY(lbl, prop, msg)
`endif
`endif

FILE: rtl/sia_pkg.sv
// shared types and constants for the signed 64-bit alu
// no dependencies
package sia_pkg;
  localparam int DataW    = 64;
  localparam int OpW      = 5;
  localparam int DivSteps = 64;
  localparam int Latency  = DivSteps + 3;

  typedef enum logic [OpW-1:0] {
    OP_ADD = 5'd0,  OP_SUB = 5'd1,  OP_MUL = 5'd2,  OP_DIV = 5'd3,
    OP_MOD = 5'd4,  OP_NEG = 5'd5,  OP_ABS = 5'd6,  OP_EQ  = 5'd7,
    OP_NE  = 5'd8,  OP_LT  = 5'd9,  OP_LE  = 5'd10, OP_GT  = 5'd11,
    OP_GE  = 5'd12, OP_AND = 5'd13, OP_OR  = 5'd14, OP_XOR = 5'd15,
    OP_NOT = 5'd16, OP_SHL = 5'd17, OP_SHR = 5'd18, OP_MIN = 5'd19,
    OP_MAX = 5'd20
  } op_t;
endpackage

FILE: rtl/signed_integer_alu_64.sv
// signed 64-bit alu: top level, fixed-latency pipeline
// depends on sia_pkg and signed_integer_alu_64_assert.svh
`include "signed_integer_alu_64_assert.svh"

// Every operation runs from the start transfer to the out_valid strobe
// through one input register, one operand stage (simple ops, operand
// magnitudes, 32x32 partial products), 64 divider stages that each resolve
// one quotient bit with a 65-bit compare and subtract, and one sign-fix
// output stage. All opcodes pass through every stage, so results come out in
// order. busy stays low: a new operation can start in every cycle, and the
// result is shown for exactly one cycle with no way for the receiver to
// hold it off.
module signed_integer_alu_64 import sia_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [OpW-1:0]          in_operation,
  input  logic signed [DataW-1:0] in_operand_a,
  input  logic signed [DataW-1:0] in_operand_b,
  output logic                    out_valid,
  output logic signed [DataW-1:0] out_result
);

  // input register
  logic             v1_r;
  logic [OpW-1:0]   op1_r;
  logic [DataW-1:0] a1_r, b1_r;

  // pipeline arrays, element 0 is the operand stage
  logic             pv_r   [0:DivSteps];
  logic             div_r  [0:DivSteps];
  logic             mod_r  [0:DivSteps];
  logic             bz_r   [0:DivSteps];
  logic             nq_r   [0:DivSteps];
  logic             nr_r   [0:DivSteps];
  logic [DataW-1:0] res_r  [0:DivSteps];
  logic [DataW-1:0] rem_r  [0:DivSteps];
  logic [DataW-1:0] quo_r  [0:DivSteps];
  logic [DataW-1:0] dvs_r  [0:DivSteps];

  logic             mul_r;
  logic [DataW-1:0] pll_r;
  logic [31:0]      plh_r, phl_r;

  logic             out_valid_r;
  logic [DataW-1:0] out_result_r;

  // operand stage logic
  logic [DataW-1:0] res_nxt, ma_nxt, mb_nxt;
  logic             lt_ab, lt_ba;
  logic [5:0]       shamt;

  always_comb begin
    lt_ab  = $signed(a1_r) < $signed(b1_r);
    lt_ba  = $signed(b1_r) < $signed(a1_r);
    shamt  = b1_r[5:0];
    ma_nxt = a1_r[DataW-1] ? (DataW'(0) - a1_r) : a1_r;
    mb_nxt = b1_r[DataW-1] ? (DataW'(0) - b1_r) : b1_r;
    case (op1_r)
      OP_ADD:  res_nxt = a1_r + b1_r;
      OP_SUB:  res_nxt = a1_r - b1_r;
      OP_NEG:  res_nxt = DataW'(0) - a1_r;
      OP_ABS:  res_nxt = ma_nxt;
      OP_EQ:   res_nxt = DataW'(a1_r == b1_r);
      OP_NE:   res_nxt = DataW'(a1_r != b1_r);
      OP_LT:   res_nxt = DataW'(lt_ab);
      OP_LE:   res_nxt = DataW'(!lt_ba);
      OP_GT:   res_nxt = DataW'(lt_ba);
      OP_GE:   res_nxt = DataW'(!lt_ab);
      OP_AND:  res_nxt = a1_r & b1_r;
      OP_OR:   res_nxt = a1_r | b1_r;
      OP_XOR:  res_nxt = a1_r ^ b1_r;
      OP_NOT:  res_nxt = ~a1_r;
      OP_SHL:  res_nxt = a1_r << shamt;
      OP_SHR:  res_nxt = DataW'($signed(a1_r) >>> shamt);
      OP_MIN:  res_nxt = lt_ab ? a1_r : b1_r;
      OP_MAX:  res_nxt = lt_ba ? a1_r : b1_r;
      default: res_nxt = '0;
    endcase
  end

  // divider step logic, one quotient bit per stage
  logic [DataW:0]   shr_nxt [1:DivSteps];
  logic [DataW:0]   dif_nxt [1:DivSteps];
  logic [DataW-1:0] rem_nxt [1:DivSteps];
  logic [DataW-1:0] quo_nxt [1:DivSteps];

  always_comb begin
    for (int k = 1; k <= DivSteps; k++) begin
      shr_nxt[k] = {rem_r[k-1], quo_r[k-1][DataW-1]};
      dif_nxt[k] = shr_nxt[k] - {1'b0, dvs_r[k-1]};
      if (!dif_nxt[k][DataW]) begin
        rem_nxt[k] = dif_nxt[k][DataW-1:0];
        quo_nxt[k] = {quo_r[k-1][DataW-2:0], 1'b1};
      end else begin
        rem_nxt[k] = shr_nxt[k][DataW-1:0];
        quo_nxt[k] = {quo_r[k-1][DataW-2:0], 1'b0};
      end
    end
  end

  logic [DataW-1:0] mul_sum;
  assign mul_sum = pll_r + {plh_r + phl_r, 32'b0};

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k <= DivSteps; k++) pv_r[k] <= 1'b0;
    end else begin
      v1_r    <= start && !busy;
      pv_r[0] <= v1_r;
      for (int k = 1; k <= DivSteps; k++) pv_r[k] <= pv_r[k-1];
      out_valid_r <= pv_r[DivSteps];
    end
  end

  // payload
  always_ff @(posedge clk) begin
    op1_r <= in_operation;
    a1_r  <= in_operand_a;
    b1_r  <= in_operand_b;

    div_r[0] <= (op1_r == OP_DIV);
    mod_r[0] <= (op1_r == OP_MOD);
    mul_r    <= (op1_r == OP_MUL);
    bz_r[0]  <= (b1_r == '0);
    nq_r[0]  <= a1_r[DataW-1] ^ b1_r[DataW-1];
    nr_r[0]  <= a1_r[DataW-1];
    res_r[0] <= res_nxt;
    rem_r[0] <= '0;
    quo_r[0] <= ma_nxt;
    dvs_r[0] <= mb_nxt;
    pll_r    <= DataW'(a1_r[31:0]) * DataW'(b1_r[31:0]);
    plh_r    <= 32'(a1_r[31:0] * b1_r[63:32]);
    phl_r    <= 32'(a1_r[63:32] * b1_r[31:0]);

    for (int k = 1; k <= DivSteps; k++) begin
      div_r[k] <= div_r[k-1];
      mod_r[k] <= mod_r[k-1];
      bz_r[k]  <= bz_r[k-1];
      nq_r[k]  <= nq_r[k-1];
      nr_r[k]  <= nr_r[k-1];
      rem_r[k] <= rem_nxt[k];
      quo_r[k] <= quo_nxt[k];
      dvs_r[k] <= dvs_r[k-1];
      if (k == 1) res_r[k] <= mul_r ? mul_sum : res_r[k-1];
      else        res_r[k] <= res_r[k-1];
    end

    // sign fix for quotient and remainder, zero on a zero divisor, other results passed through
    if ((div_r[DivSteps] || mod_r[DivSteps]) && bz_r[DivSteps])
      out_result_r <= '0;
    else if (div_r[DivSteps])
      out_result_r <= nq_r[DivSteps] ? (DataW'(0) - quo_r[DivSteps]) : quo_r[DivSteps];
    else if (mod_r[DivSteps])
      out_result_r <= nr_r[DivSteps] ? (DataW'(0) - rem_r[DivSteps]) : rem_r[DivSteps];
    else
      out_result_r <= res_r[DivSteps];
  end

  assign busy       = 1'b0;
  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

  `SIA_ASSERT(a_fixed_latency, (start && !busy) |-> ##67 out_valid, "result strobe missing")
  `SIA_ASSERT(a_rem_bound, (pv_r[DivSteps] && !bz_r[DivSteps]) |-> (rem_r[DivSteps] < dvs_r[DivSteps]), "remainder not below divisor")
  `SIA_ASSERT(a_zero_div, (pv_r[DivSteps] && bz_r[DivSteps] && (div_r[DivSteps] || mod_r[DivSteps])) |=> (out_result == '0), "zero divisor result not zero")
  `SIA_ASSERT_ANY(a_no_strobe_in_reset, !rst_n |=> !out_valid, "strobe after reset")

endmodule
